// File: hw/rtl/kpa_pkg.sv
// Shared constants and types for the keyed page allocator.
`default_nettype none

package kpa_pkg;

    localparam int MAX_PAGES = 64;
    localparam int KEY_BITS  = 64;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 64;
    localparam int PAGE_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_FIND   = 2'd1,
        OP_FREE   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_POP,
        S_ALLOC,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/kpa_if.sv
// Valid/ready channel interfaces for the request and result streams.
`default_nettype none

interface kpa_in_if;
    logic                         valid;
    logic                         ready;
    logic [kpa_pkg::OP_W-1:0]     operation;
    logic [kpa_pkg::KEY_W-1:0]    lookup_key;
    logic [kpa_pkg::PAGE_W-1:0]   page_to_free;

    modport source (output valid, output operation, output lookup_key,
                    output page_to_free, input ready);
    modport sink   (input valid, input operation, input lookup_key,
                    input page_to_free, output ready);
endinterface

interface kpa_out_if;
    logic                         valid;
    logic                         ready;
    logic [kpa_pkg::PAGE_W-1:0]   page_index;
    logic                         was_hit;
    logic                         success;
    logic [kpa_pkg::CNT_W-1:0]    active_pages;

    modport source (output valid, output page_index, output was_hit,
                    output success, output active_pages, input ready);
    modport sink   (input valid, input page_index, input was_hit,
                    input success, input active_pages, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/keyed_page_allocator.sv
// Page pool with a tag memory scanned per request and a LIFO free stack memory.
// One item at a time: a request is taken only in idle, after the last result is registered.
// The tag scan reads the entry memory one page per cycle and sets the rate.
// Reset and every pool size write start a clearing pass over all MAX_PAGES pages
// that invalidates them and reloads the stack; no request is taken then.
`default_nettype none

module keyed_page_allocator #(
    parameter int MAX_PAGES = kpa_pkg::MAX_PAGES,
    parameter int KEY_BITS  = kpa_pkg::KEY_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [kpa_pkg::CNT_W-1:0]   i_cfg_wdata,
    kpa_in_if.sink                           i_in,
    kpa_out_if.source                        o_out
);

    localparam int PW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int EW        = KEY_BITS + 1;
    localparam int CW        = kpa_pkg::CNT_W;
    localparam int RST_PAGES = (MAX_PAGES < 64) ? MAX_PAGES : 64;

    kpa_pkg::t_state r_state, n_state;

    logic [PW-1:0]                r_clr, n_clr;
    logic [CW-1:0]                r_pages, n_pages;
    logic [CW-1:0]                r_free_top, n_free_top;
    logic [CW-1:0]                r_alloc, n_alloc;
    logic [CW-1:0]                r_scan, n_scan;
    logic                         r_pend, n_pend;
    logic [kpa_pkg::OP_W-1:0]     r_op, n_op;
    logic [KEY_BITS-1:0]          r_key, n_key;
    logic [kpa_pkg::PAGE_W-1:0]   r_victim, n_victim;
    logic [kpa_pkg::PAGE_W-1:0]   r_res_page, n_res_page;
    logic                         r_res_hit, n_res_hit;
    logic                         r_res_ok, n_res_ok;
    logic                         r_out_valid, n_out_valid;
    logic [kpa_pkg::PAGE_W-1:0]   r_out_page, n_out_page;
    logic                         r_out_hit, n_out_hit;
    logic                         r_out_ok, n_out_ok;
    logic [CW-1:0]                r_out_active, n_out_active;

    logic                         in_ready;
    logic [CW-1:0]                cfg_pages;

    logic                         ent_we;
    logic [PW-1:0]                ent_waddr;
    logic [EW-1:0]                ent_wdata;
    logic [PW-1:0]                ent_raddr;
    logic [EW-1:0]                ent_rdata;
    logic                         stk_we;
    logic [PW-1:0]                stk_waddr;
    logic [PW-1:0]                stk_wdata;
    logic [PW-1:0]                stk_raddr;
    logic [PW-1:0]                stk_rdata;

    // Each entry holds the valid bit above the tag.
    kpa_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    kpa_ram #(.WIDTH(PW), .DEPTH(MAX_PAGES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        cfg_pages = i_cfg_wdata;
        if (cfg_pages == '0) begin
            cfg_pages = CW'(1);
        end
        if (int'(cfg_pages) > MAX_PAGES) begin
            cfg_pages = CW'(MAX_PAGES);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pages      = r_pages;
        n_free_top   = r_free_top;
        n_alloc      = r_alloc;
        n_scan       = r_scan;
        n_pend       = r_pend;
        n_op         = r_op;
        n_key        = r_key;
        n_victim     = r_victim;
        n_res_page   = r_res_page;
        n_res_hit    = r_res_hit;
        n_res_ok     = r_res_ok;
        n_out_valid  = r_out_valid;
        n_out_page   = r_out_page;
        n_out_hit    = r_out_hit;
        n_out_ok     = r_out_ok;
        n_out_active = r_out_active;

        // A pool size write in the same cycle would discard the transaction.
        in_ready  = (r_state == kpa_pkg::S_IDLE) && !i_cfg_we;
        ent_we    = 1'b0;
        ent_waddr = '0;
        ent_wdata = '0;
        ent_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            kpa_pkg::S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr;
                ent_wdata = '0;
                stk_we    = 1'b1;
                stk_waddr = r_clr;
                stk_wdata = r_clr;
                if (r_clr == PW'(MAX_PAGES - 1)) begin
                    n_state = kpa_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            kpa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op       = i_in.operation;
                    n_key      = i_in.lookup_key[KEY_BITS-1:0];
                    n_victim   = i_in.page_to_free;
                    n_scan     = '0;
                    n_pend     = 1'b0;
                    n_res_page = '0;
                    n_res_hit  = 1'b0;
                    n_res_ok   = 1'b0;
                    case (i_in.operation)
                        kpa_pkg::OP_LOOKUP, kpa_pkg::OP_FIND: n_state = kpa_pkg::S_SCAN;
                        kpa_pkg::OP_FREE:                     n_state = kpa_pkg::S_FREE_RD;
                        default:                              n_state = kpa_pkg::S_DONE;
                    endcase
                end
            end
            kpa_pkg::S_SCAN: begin
                ent_raddr = PW'(r_scan);
                // The data on the read port belongs to the page issued last cycle.
                if (r_pend && ent_rdata[KEY_BITS] && ent_rdata[KEY_BITS-1:0] == r_key) begin
                    n_res_page = kpa_pkg::PAGE_W'(r_scan - 1'b1);
                    n_res_hit  = 1'b1;
                    n_res_ok   = 1'b1;
                    n_state    = kpa_pkg::S_DONE;
                end else if (r_scan < r_pages) begin
                    n_scan = r_scan + 1'b1;
                    n_pend = 1'b1;
                end else if (r_op == kpa_pkg::OP_FIND && r_free_top != '0) begin
                    n_state = kpa_pkg::S_POP;
                end else begin
                    n_state = kpa_pkg::S_DONE;
                end
            end
            kpa_pkg::S_POP: begin
                stk_raddr = PW'(r_free_top - 1'b1);
                n_state   = kpa_pkg::S_ALLOC;
            end
            kpa_pkg::S_ALLOC: begin
                ent_we     = 1'b1;
                ent_waddr  = stk_rdata;
                ent_wdata  = {1'b1, r_key};
                n_free_top = r_free_top - 1'b1;
                n_alloc    = r_alloc + 1'b1;
                n_res_page = kpa_pkg::PAGE_W'(stk_rdata);
                n_res_ok   = 1'b1;
                n_state    = kpa_pkg::S_DONE;
            end
            kpa_pkg::S_FREE_RD: begin
                ent_raddr = PW'(r_victim);
                if ({1'b0, r_victim} < r_pages) begin
                    n_state = kpa_pkg::S_FREE_CHK;
                end else begin
                    n_state = kpa_pkg::S_DONE;
                end
            end
            kpa_pkg::S_FREE_CHK: begin
                if (ent_rdata[KEY_BITS] && int'(r_free_top) < MAX_PAGES) begin
                    ent_we     = 1'b1;
                    ent_waddr  = PW'(r_victim);
                    ent_wdata  = {1'b0, ent_rdata[KEY_BITS-1:0]};
                    stk_we     = 1'b1;
                    stk_waddr  = PW'(r_free_top);
                    stk_wdata  = PW'(r_victim);
                    n_free_top = r_free_top + 1'b1;
                    if (r_alloc != '0) begin
                        n_alloc = r_alloc - 1'b1;
                    end
                    n_res_page = r_victim;
                    n_res_ok   = 1'b1;
                end
                n_state = kpa_pkg::S_DONE;
            end
            kpa_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_page   = r_res_page;
                    n_out_hit    = r_res_hit;
                    n_out_ok     = r_res_ok;
                    n_out_active = r_alloc;
                    n_state      = kpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kpa_pkg::S_IDLE;
            end
        endcase

        // A pool size write restarts the pool from scratch.
        if (i_cfg_we) begin
            n_pages    = cfg_pages;
            n_free_top = cfg_pages;
            n_alloc    = '0;
            n_clr      = '0;
            n_state    = kpa_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kpa_pkg::S_CLEAR;
            r_clr       <= '0;
            r_pages     <= CW'(RST_PAGES);
            r_free_top  <= CW'(RST_PAGES);
            r_alloc     <= '0;
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pages     <= n_pages;
            r_free_top  <= n_free_top;
            r_alloc     <= n_alloc;
            r_scan      <= n_scan;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_victim     <= n_victim;
        r_res_page   <= n_res_page;
        r_res_hit    <= n_res_hit;
        r_res_ok     <= n_res_ok;
        r_out_page   <= n_out_page;
        r_out_hit    <= n_out_hit;
        r_out_ok     <= n_out_ok;
        r_out_active <= n_out_active;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.page_index   = r_out_page;
    assign o_out.was_hit      = r_out_hit;
    assign o_out.success      = r_out_ok;
    assign o_out.active_pages = r_out_active;

`ifndef ASSERT_OFF
    // Every page of the pool is either on the free stack or allocated.
    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (8'(r_free_top) + 8'(r_alloc)) == 8'(r_pages))
        else $error("free stack depth and allocated count do not add up to the pool");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_cfg_we) |=> (r_state != kpa_pkg::S_IDLE))
        else $error("request accepted but no work started");

    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.success) |-> (o_out.page_index == '0 && !o_out.was_hit))
        else $error("failed transaction reports a page or a hit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/kpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module kpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: test/kpa_checker.sv
// Checker for the keyed page allocator: predicts every result from the accepted requests.
module kpa_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [kpa_pkg::CNT_W-1:0]  i_cfg_wdata,
    kpa_in_if                               i_req,
    kpa_out_if                              i_res,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [kpa_pkg::PAGE_W-1:0] page_index;
        logic                       was_hit;
        logic                       success;
        logic [kpa_pkg::CNT_W-1:0]  active_pages;
    } t_page_result;

    logic [kpa_pkg::KEY_W-1:0]  tag_mem    [kpa_pkg::MAX_PAGES];
    bit                         page_live  [kpa_pkg::MAX_PAGES];
    logic [kpa_pkg::PAGE_W-1:0] free_pages [kpa_pkg::MAX_PAGES];
    int                         free_depth;
    int                         live_count;
    int                         pool_size;
    int                         result_no;
    t_page_result               expected_results[$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        result_no   = 0;
    end

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_err_count++;
    endtask

    // Invalidates every page and reloads the free stack with 0..n-1.
    task automatic rebuild_pool(input int n);
        pool_size = n;
        for (int i = 0; i < kpa_pkg::MAX_PAGES; i++) begin
            free_pages[i] = i[kpa_pkg::PAGE_W-1:0];
            page_live[i]  = 1'b0;
        end
        free_depth = n;
        live_count = 0;
    endtask

    function automatic int clamp_pool(input logic [kpa_pkg::CNT_W-1:0] value);
        if (value == 0) return 1;
        if (value > kpa_pkg::MAX_PAGES) return kpa_pkg::MAX_PAGES;
        return int'(value);
    endfunction

    task automatic predict_page_result(input logic [kpa_pkg::OP_W-1:0] op,
                                       input logic [kpa_pkg::KEY_W-1:0] key,
                                       input logic [kpa_pkg::PAGE_W-1:0] victim,
                                       output t_page_result res);
        int                         found;
        logic [kpa_pkg::PAGE_W-1:0] pg;
        res   = '0;
        found = -1;
        if (op == kpa_pkg::OP_LOOKUP || op == kpa_pkg::OP_FIND) begin
            // The lowest matching live page wins.
            for (int i = 0; i < pool_size; i++) begin
                if (found < 0 && page_live[i] && tag_mem[i] == key) found = i;
            end
            if (found >= 0) begin
                res.page_index = found[kpa_pkg::PAGE_W-1:0];
                res.was_hit    = 1'b1;
                res.success    = 1'b1;
            end else if (op == kpa_pkg::OP_FIND && free_depth > 0) begin
                free_depth--;
                pg             = free_pages[free_depth];
                tag_mem[pg]    = key;
                page_live[pg]  = 1'b1;
                live_count++;
                res.page_index = pg;
                res.success    = 1'b1;
            end
        end else if (op == kpa_pkg::OP_FREE) begin
            if (victim < pool_size && page_live[victim]
                && free_depth < kpa_pkg::MAX_PAGES) begin
                page_live[victim]      = 1'b0;
                free_pages[free_depth] = victim;
                free_depth++;
                if (live_count > 0) live_count--;
                res.page_index = victim;
                res.success    = 1'b1;
            end
        end
        res.active_pages = live_count[kpa_pkg::CNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_page_result want;
        t_page_result got;
        if (!i_rst_n) begin
            rebuild_pool(kpa_pkg::MAX_PAGES);
            expected_results.delete();
        end else begin
            if (i_cfg_we) rebuild_pool(clamp_pool(i_cfg_wdata));
            if (i_res.valid && i_res.ready) begin
                got.page_index   = i_res.page_index;
                got.was_hit      = i_res.was_hit;
                got.success      = i_res.success;
                got.active_pages = i_res.active_pages;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with no request pending",
                                         result_no));
                end else begin
                    want = expected_results.pop_front();
                    if (got.page_index !== want.page_index)
                        flag_error($sformatf("result %0d page_index expected %0d got %0d",
                                             result_no, want.page_index, got.page_index));
                    if (got.was_hit !== want.was_hit)
                        flag_error($sformatf("result %0d was_hit expected %0b got %0b",
                                             result_no, want.was_hit, got.was_hit));
                    if (got.success !== want.success)
                        flag_error($sformatf("result %0d success expected %0b got %0b",
                                             result_no, want.success, got.success));
                    if (got.active_pages !== want.active_pages)
                        flag_error($sformatf("result %0d active_pages expected %0d got %0d",
                                             result_no, want.active_pages, got.active_pages));
                end
                result_no++;
            end
            if (i_req.valid && i_req.ready) begin
                predict_page_result(i_req.operation, i_req.lookup_key, i_req.page_to_free,
                                    want);
                expected_results = {expected_results, want};
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: test/tb_keyed_page_allocator.sv
// Testbench top for the keyed page allocator: clock, reset, stimulus and verdict.
module tb_keyed_page_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [kpa_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int HOLD_AFTER   = 300;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 195;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [kpa_pkg::CNT_W-1:0] i_cfg_wdata;
    int                        err_count;
    int                        pending;
    int                        cycle_count;
    bit                        quiet_phase;

    kpa_in_if  req_ch();
    kpa_out_if res_ch();

    keyed_page_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    kpa_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none during a quiet phase.
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // Called at a falling edge; returns at a falling edge after the transaction.
    task automatic send_item(input logic [kpa_pkg::OP_W-1:0] op,
                             input logic [kpa_pkg::KEY_W-1:0] key,
                             input logic [kpa_pkg::PAGE_W-1:0] page);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.lookup_key   <= key;
        req_ch.page_to_free <= page;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic end_burst();
        req_ch.valid <= 1'b0;
    endtask

    // The pool size register may only change once every result is back.
    task automatic write_pool_size(input logic [kpa_pkg::CNT_W-1:0] value);
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items, input int pool_n);
        logic [kpa_pkg::KEY_W-1:0]  keys [16];
        int                         nkeys;
        int                         r;
        logic [kpa_pkg::OP_W-1:0]   op;
        logic [kpa_pkg::KEY_W-1:0]  k;
        logic [kpa_pkg::PAGE_W-1:0] pg;
        nkeys = $urandom_range(2, 16);
        for (int i = 0; i < 16; i++) keys[i] = {$urandom, $urandom};
        repeat (n_items) begin
            r  = $urandom_range(0, 99);
            k  = {$urandom, $urandom};
            pg = kpa_pkg::PAGE_W'($urandom_range(0, kpa_pkg::MAX_PAGES - 1));
            if (r < 45) begin
                op = kpa_pkg::OP_FIND;
                if ($urandom_range(0, 3) != 0) k = keys[$urandom_range(0, nkeys - 1)];
            end else if (r < 70) begin
                op = kpa_pkg::OP_LOOKUP;
                if ($urandom_range(0, 9) < 7) k = keys[$urandom_range(0, nkeys - 1)];
            end else if (r < 95) begin
                op = kpa_pkg::OP_FREE;
                if ($urandom_range(0, 4) != 0) begin
                    pg = kpa_pkg::PAGE_W'($urandom_range(0, pool_n - 1));
                end
            end else begin
                op = OP_RESERVED;
            end
            send_item(op, k, pg);
        end
        end_burst();
    endtask

    initial begin
        int phase_cfg [8];
        int n_eff;
        phase_cfg = '{3, 64, 1, 12, 127, 2, 0, 40};
        phase_cfg[6] = $urandom_range(1, 64);
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = kpa_pkg::OP_LOOKUP;
        req_ch.lookup_key   = '0;
        req_ch.page_to_free = '0;
        quiet_phase         = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full pool after reset: allocation order, hits, misses, bad frees.
        send_item(kpa_pkg::OP_FIND,   64'h0, 6'd0);
        send_item(kpa_pkg::OP_FIND,   {kpa_pkg::KEY_W{1'b1}}, 6'd63);
        send_item(kpa_pkg::OP_LOOKUP, 64'h0, 6'd63);
        send_item(kpa_pkg::OP_LOOKUP, {kpa_pkg::KEY_W{1'b1}}, 6'd0);
        send_item(kpa_pkg::OP_FIND,   {kpa_pkg::KEY_W{1'b1}}, 6'd0);
        send_item(kpa_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, 6'd0);
        send_item(kpa_pkg::OP_FREE,   64'h0, 6'd63);
        send_item(kpa_pkg::OP_FREE,   {kpa_pkg::KEY_W{1'b1}}, 6'd63);
        send_item(kpa_pkg::OP_FREE,   64'h0, 6'd0);
        send_item(OP_RESERVED,        {kpa_pkg::KEY_W{1'b1}}, 6'd63);
        send_item(kpa_pkg::OP_LOOKUP, 64'h0, 6'd0);
        end_burst();

        // A written zero means a single page: empty pool and out-of-range frees.
        write_pool_size(7'd0);
        send_item(kpa_pkg::OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_item(kpa_pkg::OP_FIND,   64'h5555_5555_5555_5555, 6'd0);
        send_item(kpa_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_item(kpa_pkg::OP_FREE,   64'h0, 6'd1);
        send_item(kpa_pkg::OP_FREE,   64'h0, 6'd63);
        send_item(kpa_pkg::OP_FREE,   64'h0, 6'd0);
        send_item(kpa_pkg::OP_FIND,   64'h5555_5555_5555_5555, 6'd0);
        end_burst();

        for (int ph = 0; ph < 8; ph++) begin
            write_pool_size(phase_cfg[ph][kpa_pkg::CNT_W-1:0]);
            n_eff = phase_cfg[ph] == 0 ? 1 :
                    (phase_cfg[ph] > kpa_pkg::MAX_PAGES ? kpa_pkg::MAX_PAGES : phase_cfg[ph]);
            quiet_phase = (ph == 1 || ph == 5);
            run_random_phase(PHASE_ITEMS, n_eff);
        end
        quiet_phase = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold while requests keep coming.
    initial begin
        int gap;
        int results_seen;
        results_seen = 0;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_seen == HOLD_AFTER) gap = LONG_HOLD;
            else gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            results_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
